// ===== design/naf_pkg.sv =====
// shared constants, types and helper functions of the neighbour average filter
`default_nettype none

package naf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int CHANNELS    = 3;

  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W    = CHANNELS * SAMPLE_BITS;
  localparam int TDATA_W  = ((PIX_W + 7) / 8) * 8;

  // sums of up to five samples, divided through a reciprocal
  localparam int SUM_W    = SAMPLE_BITS + 3;
  localparam int CNT_W    = 3;
  localparam int SHIFT    = SUM_W + 2;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint RECIP3 = ((64'd1 << SHIFT) + 64'd2) / 3;
  localparam longint RECIP5 = ((64'd1 << SHIFT) + 64'd4) / 5;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] pix_t;
  typedef logic [CHANNELS-1:0][SUM_W-1:0]       sum_t;
  typedef logic [CHANNELS-1:0][PROD_W-1:0]      prod_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [CFG_W-1:0] raw);
    logic [WIDTH_W-1:0] w;
    if (raw == '0) begin
      w = WIDTH_W'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      w = WIDTH_W'(MAX_WIDTH);
    end else begin
      w = WIDTH_W'(raw);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [CFG_W-1:0] raw);
    logic [ROW_W-1:0] h;
    if (raw == '0) begin
      h = ROW_W'(1);
    end else if (int'(raw) > MAX_HEIGHT) begin
      h = ROW_W'(MAX_HEIGHT);
    end else begin
      h = ROW_W'(raw);
    end
    return h;
  endfunction

  // reciprocal of the neighbour count, scaled by 2^SHIFT
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      3'd1:    m = RECIP_W'(1) << SHIFT;
      3'd2:    m = RECIP_W'(1) << (SHIFT - 1);
      3'd3:    m = RECIP_W'(RECIP3);
      3'd4:    m = RECIP_W'(1) << (SHIFT - 2);
      3'd5:    m = RECIP_W'(RECIP5);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/naf_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module naf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/neighbour_average_filter_top.sv =====
// neighbour average filter: line store, read sequencer, divider and output register
`default_nettype none

// Averages each pixel of a raster-order three-channel frame with its in-bounds
// right, left, lower-left and lower neighbours (unsigned Q1.15 samples,
// truncated quotients). Results trail the input by one row: pixels of the first
// row give no result, each later pixel gives the result for the pixel above it,
// and once all rows are in, one flush transaction (tuser set) drains one pixel
// of the last row; tlast marks the final pixel of the frame. Pixels are ignored
// while draining and flushes are ignored while rows still arrive. A pixel of the
// first row or an ignored transaction leaves the sequencer idle; a pixel with a
// result or a flush holds off the next transaction while the single read port
// of the line store reads two or three columns in turn, followed by the multiply
// and the output load. The output load, and the next transaction with it, waits
// while the output register holds an earlier result not yet taken; a finished
// result waits there while the next transaction is taken. The user must write
// frame_width and frame_height through the cfg port only between transactions;
// the block does not enforce this. 0 acts as 1 and larger values are clipped to
// 2048. The line store needs no clearing after reset: each entry is written
// before it is read.
module neighbour_average_filter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_we_i,
  input  wire logic [naf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [naf_pkg::CFG_W-1:0]     cfg_data_i,

  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // sample_x, sample_y, sample_z
  input  wire logic [naf_pkg::TDATA_W-1:0]   s_axis_tdata,
  // opcode
  input  wire logic [0:0]                    s_axis_tuser,

  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // mean_x, mean_y, mean_z
  output      logic [naf_pkg::TDATA_W-1:0]   m_axis_tdata,
  // frame_last
  output      logic                          m_axis_tlast
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;   // entry at the column arrives
  localparam logic [2:0] S_RD2  = 3'd2;   // entry to the right arrives
  localparam logic [2:0] S_RD3  = 3'd3;   // entry to the left arrives (flush)
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [naf_pkg::CFG_W-1:0]   width_q, height_q;
  logic [naf_pkg::WIDTH_W-1:0] w_eff;
  logic [naf_pkg::ROW_W-1:0]   h_eff;

  // frame position
  logic [naf_pkg::COL_W-1:0] in_col_q, in_col_d;
  logic [naf_pkg::ROW_W-1:0] in_row_q, in_row_d;
  logic [naf_pkg::COL_W-1:0] out_col_q, out_col_d;

  // neighbours held outside the line store
  naf_pkg::pix_t lower_left_q, lower_left_d;
  naf_pkg::pix_t held_q, held_d;

  // transaction in flight
  logic [naf_pkg::COL_W-1:0] col_q, col_d;
  logic                      flush_q, flush_d;
  logic                      right_ok_q, right_ok_d;
  logic                      left_ok_q, left_ok_d;
  logic                      last_q, last_d;
  logic [naf_pkg::CNT_W-1:0] count_q, count_d;
  naf_pkg::sum_t             sum_q, sum_d;
  naf_pkg::prod_t            prod_q, prod_d;

  // output register
  logic          out_valid_q, out_valid_d;
  naf_pkg::pix_t out_pix_q, out_pix_d;
  logic          out_last_q, out_last_d;

  // line store port
  logic                      ram_we;
  logic [naf_pkg::COL_W-1:0] ram_waddr, ram_raddr;
  naf_pkg::pix_t             ram_wdata, ram_rdata;

  logic                        s_accept;
  logic                        op;
  naf_pkg::pix_t               in_pix;
  logic [naf_pkg::WIDTH_W-1:0] in_col_next, out_col_next;
  logic                        in_right, out_right;
  logic                        rows_pending;
  logic                        out_load;

  assign w_eff = naf_pkg::eff_width(width_q);
  assign h_eff = naf_pkg::eff_height(height_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser[0];
  assign in_pix        = naf_pkg::pix_t'(s_axis_tdata[naf_pkg::PIX_W-1:0]);

  assign in_col_next  = naf_pkg::WIDTH_W'(in_col_q) + naf_pkg::WIDTH_W'(1);
  assign out_col_next = naf_pkg::WIDTH_W'(out_col_q) + naf_pkg::WIDTH_W'(1);
  assign in_right     = (in_col_next < w_eff);
  assign out_right    = (out_col_next < w_eff);
  assign rows_pending = (in_row_q < h_eff);

  // the store is written with the pixel on acceptance; its read of the same
  // column in that cycle still returns the pending-row pixel
  assign ram_we    = s_accept && (op == naf_pkg::OP_PIXEL) && rows_pending;
  assign ram_waddr = in_col_q;
  assign ram_wdata = in_pix;

  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = (op == naf_pkg::OP_FLUSH) ? out_col_q : in_col_q;
      S_RD1:   ram_raddr = col_q + naf_pkg::COL_W'(1);
      S_RD2:   ram_raddr = col_q - naf_pkg::COL_W'(1);
      default: ram_raddr = col_q;
    endcase
  end

  naf_ram #(
    .WIDTH (naf_pkg::PIX_W),
    .DEPTH (naf_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    lower_left_d = lower_left_q;
    held_d       = held_q;
    col_d        = col_q;
    flush_d      = flush_q;
    right_ok_d   = right_ok_q;
    left_ok_d    = left_ok_q;
    last_d       = last_q;
    count_d      = count_q;
    sum_d        = sum_q;
    prod_d       = prod_q;
    out_pix_d    = out_pix_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        if (s_accept && (op == naf_pkg::OP_PIXEL) && rows_pending) begin
          lower_left_d = in_pix;
          if (in_right) begin
            in_col_d = in_col_next[naf_pkg::COL_W-1:0];
          end else begin
            in_col_d = '0;
            in_row_d = in_row_q + naf_pkg::ROW_W'(1);
          end
          // every row but the first produces the result for the row above
          if (in_row_q != '0) begin
            col_d      = in_col_q;
            flush_d    = 1'b0;
            right_ok_d = in_right;
            left_ok_d  = (in_col_q != '0);
            last_d     = 1'b0;
            count_d    = naf_pkg::CNT_W'(2) + naf_pkg::CNT_W'(in_right)
                       + ((in_col_q != '0) ? naf_pkg::CNT_W'(2) : '0);
            for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
              sum_d[k] = naf_pkg::SUM_W'(in_pix[k]);
              if (in_col_q != '0) begin
                sum_d[k] = sum_d[k] + naf_pkg::SUM_W'(held_q[k])
                         + naf_pkg::SUM_W'(lower_left_q[k]);
              end
            end
            out_col_d = in_right ? in_col_next[naf_pkg::COL_W-1:0] : '0;
            state_d   = S_RD1;
          end
        end else if (s_accept && (op == naf_pkg::OP_FLUSH) && !rows_pending) begin
          col_d      = out_col_q;
          flush_d    = 1'b1;
          right_ok_d = out_right;
          left_ok_d  = (out_col_q != '0);
          last_d     = !out_right;
          count_d    = naf_pkg::CNT_W'(1) + naf_pkg::CNT_W'(out_right)
                     + naf_pkg::CNT_W'(out_col_q != '0);
          sum_d      = '0;
          if (out_right) begin
            out_col_d = out_col_next[naf_pkg::COL_W-1:0];
          end else begin
            // final pixel of the frame: back to the start
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
          end
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
          sum_d[k] = sum_q[k] + naf_pkg::SUM_W'(ram_rdata[k]);
        end
        if (!flush_q) begin
          held_d = ram_rdata;
        end
        state_d = S_RD2;
      end
      S_RD2: begin
        if (right_ok_q) begin
          for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
            sum_d[k] = sum_q[k] + naf_pkg::SUM_W'(ram_rdata[k]);
          end
        end
        state_d = flush_q ? S_RD3 : S_MUL;
      end
      S_RD3: begin
        if (left_ok_q) begin
          for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
            sum_d[k] = sum_q[k] + naf_pkg::SUM_W'(ram_rdata[k]);
          end
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
          prod_d[k] = naf_pkg::PROD_W'(sum_q[k])
                    * naf_pkg::PROD_W'(naf_pkg::recip(count_q));
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          for (int k = 0; k < naf_pkg::CHANNELS; k++) begin
            out_pix_d[k] = prod_q[k][naf_pkg::SHIFT +: naf_pkg::SAMPLE_BITS];
          end
          out_last_d  = last_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      width_q      <= naf_pkg::FRAME_WIDTH_RST;
      height_q     <= naf_pkg::FRAME_HEIGHT_RST;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      lower_left_q <= '0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      lower_left_q <= lower_left_d;
      held_q       <= held_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          naf_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          naf_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    flush_q    <= flush_d;
    right_ok_q <= right_ok_d;
    left_ok_q  <= left_ok_d;
    last_q     <= last_d;
    count_q    <= count_d;
    sum_q      <= sum_d;
    prod_q     <= prod_d;
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = naf_pkg::TDATA_W'(out_pix_q);
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== design/naf_checker.sv =====
// port-level checks of the neighbour average filter and their binding
`default_nettype none

module naf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [naf_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic                        m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a result follows its transaction only after the line store reads
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after acceptance");

  // the output register is loaded only from the busy sequencer
  a_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result loaded while idle");

endmodule

bind neighbour_average_filter_top naf_checker u_naf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
